@@ rtl/lsp_pkg.sv @@
package lsp_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int          ENTRY_W       = 10;
    localparam int          DIV_STEPS     = 32;
    localparam logic [15:0] MODULUS_RESET = 16'd16873;
    localparam logic [15:0] SEED_RESET    = 16'd8;
    localparam logic [7:0]  NICE_DEFAULT  = 8'd120;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [1:0] SLOT_UNUSED   = 2'd0;
    localparam logic [1:0] SLOT_WAITING  = 2'd1;
    localparam logic [1:0] SLOT_RUNNABLE = 2'd2;
    localparam logic [1:0] SLOT_RUNNING  = 2'd3;

    localparam logic REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        LSP_IDLE,
        LSP_SET_RD,
        LSP_SET_WR,
        LSP_MUL,
        LSP_MOD_SEED,
        LSP_MOD_DRAW,
        LSP_SCAN,
        LSP_DONE
    } lsp_state_t;

    function automatic logic [2:0] tickets_of(input logic [7:0] nice);
        logic [2:0] t;
        if (nice == 8'd139)
            t = 3'd1;
        else if (nice >= 8'd130 && nice <= 8'd138)
            t = 3'd2;
        else if (nice >= 8'd120 && nice <= 8'd129)
            t = 3'd3;
        else if (nice >= 8'd110 && nice <= 8'd119)
            t = 3'd4;
        else if (nice >= 8'd101 && nice <= 8'd109)
            t = 3'd5;
        else if (nice == 8'd100)
            t = 3'd6;
        else
            t = 3'd3;
        return t;
    endfunction

    function automatic logic [7:0] fix_nice(input logic [7:0] nice);
        logic [7:0] f;
        if (nice >= 8'd100 && nice <= 8'd139)
            f = nice;
        else
            f = NICE_DEFAULT;
        return f;
    endfunction

endpackage

@@ rtl/lottery_slot_picker_top.sv @@
// set: slot read, slot write, done; a draw on an empty total goes straight to done
// a draw takes a squaring step, two 32-step remainder passes
// in the shared shift-subtract unit, then a scan of the slot memory at one entry a cycle
// one item is worked on at a time; the next is taken once the result sits in the output register
// reset clears every slot to unused at once (per-entry valid bits), seed 8, modulus 16873
module lottery_slot_picker_top #(
    parameter int SLOTS = lsp_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [5:0]  slot,
    input  logic [1:0]  new_state,
    input  logic [7:0]  nice_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [5:0]  winner_slot,
    output logic [8:0]  draw_value,
    output logic [8:0]  ticket_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW        = $clog2(SLOTS);
    localparam int TW        = $clog2(6 * SLOTS + 1);
    localparam int TOTAL_MAX = 6 * SLOTS;

    lsp_pkg::lsp_state_t state_reg, state_next;

    logic [15:0]   modulus_reg;
    logic [15:0]   seed_reg;
    logic [TW-1:0] total_reg, total_next;
    logic [SLOTS-1:0] valid_reg;

    logic          op_reg;
    logic [IW-1:0] slot_reg;
    logic [1:0]    new_state_reg;
    logic [7:0]    nice_reg;

    logic [31:0]   div_dvd_reg;
    logic [16:0]   div_rem_reg;
    logic [16:0]   div_dsr_reg;
    logic [4:0]    div_cnt_reg;

    logic [IW-1:0] issue_idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_live_reg;
    logic          rd_valid_reg;
    logic [TW-1:0] sum_reg;

    logic          res_found_reg;
    logic [IW-1:0] res_winner_reg;
    logic [TW-1:0] res_draw_reg;

    logic          out_valid_reg;
    logic          found_reg;
    logic [5:0]    winner_slot_reg;
    logic [8:0]    draw_value_reg;
    logic [8:0]    ticket_total_reg;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [lsp_pkg::ENTRY_W-1:0] mem_wdata;
    logic [IW-1:0]         mem_raddr;
    logic [lsp_pkg::ENTRY_W-1:0] mem_rdata;

    logic          accept;
    logic          out_free;
    logic          slot_in_range;
    logic          cfg_write;

    logic [17:0]   div_trial;
    logic [16:0]   div_rem_step;
    logic          div_last;

    logic [1:0]    rd_status;
    logic [2:0]    rd_tickets;
    logic          rd_hit;
    logic [TW-1:0] sum_step;
    logic          scan_win;
    logic          scan_last;

    logic [1:0]    old_status;
    logic [TW-1:0] old_tickets;
    logic [TW-1:0] new_tickets;

    lsp_ram #(
        .WIDTH (lsp_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept        = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign slot_in_range = (32'(slot) < SLOTS);
    assign cfg_write     = psel && penable && pwrite && pready;

    // shared shift-subtract remainder step
    assign div_trial    = {div_rem_reg, div_dvd_reg[31]};
    assign div_rem_step = (div_trial >= {1'b0, div_dsr_reg}) ?
                          17'(div_trial - {1'b0, div_dsr_reg}) : div_trial[16:0];
    assign div_last     = (div_cnt_reg == 5'(lsp_pkg::DIV_STEPS - 1));

    // scan of one memory entry
    assign rd_status  = rd_valid_reg ? mem_rdata[9:8] : lsp_pkg::SLOT_UNUSED;
    assign rd_tickets = lsp_pkg::tickets_of(mem_rdata[7:0]);
    assign rd_hit     = rd_live_reg && (rd_status == lsp_pkg::SLOT_RUNNABLE);
    assign sum_step   = sum_reg + (rd_hit ? TW'(rd_tickets) : '0);
    assign scan_win   = rd_hit && (sum_step > res_draw_reg);
    assign scan_last  = rd_live_reg && (rd_idx_reg == IW'(SLOTS - 1));

    // set: replace old tickets by new ones
    assign old_status  = rd_status;
    assign old_tickets = (old_status != lsp_pkg::SLOT_UNUSED) ? TW'(rd_tickets) : '0;
    assign new_tickets = (new_state_reg != lsp_pkg::SLOT_UNUSED) ?
                         TW'(lsp_pkg::tickets_of(nice_reg)) : '0;
    assign total_next  = total_reg - old_tickets + new_tickets;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsp_pkg::LSP_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == lsp_pkg::OP_SET)
                        state_next = slot_in_range ? lsp_pkg::LSP_SET_RD : lsp_pkg::LSP_DONE;
                    else
                        state_next = (total_reg != '0) ? lsp_pkg::LSP_MUL : lsp_pkg::LSP_DONE;
                end
            end
            lsp_pkg::LSP_SET_RD:   state_next = lsp_pkg::LSP_SET_WR;
            lsp_pkg::LSP_SET_WR:   state_next = lsp_pkg::LSP_DONE;
            lsp_pkg::LSP_MUL:      state_next = lsp_pkg::LSP_MOD_SEED;
            lsp_pkg::LSP_MOD_SEED:
            begin
                if (div_last)
                    state_next = lsp_pkg::LSP_MOD_DRAW;
            end
            lsp_pkg::LSP_MOD_DRAW:
            begin
                if (div_last)
                    state_next = lsp_pkg::LSP_SCAN;
            end
            lsp_pkg::LSP_SCAN:
            begin
                if (scan_win || scan_last)
                    state_next = lsp_pkg::LSP_DONE;
            end
            lsp_pkg::LSP_DONE:
            begin
                if (out_free)
                    state_next = lsp_pkg::LSP_IDLE;
            end
            default:               state_next = lsp_pkg::LSP_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = {new_state_reg, lsp_pkg::fix_nice(nice_reg)};
        mem_raddr = slot_reg;
        case (state_reg)
            lsp_pkg::LSP_IDLE:   in_stall = 1'b0;
            lsp_pkg::LSP_SET_WR: mem_we = 1'b1;
            lsp_pkg::LSP_SCAN:
            begin
                mem_raddr = issue_idx_reg;
                mem_we    = scan_win;
                mem_waddr = rd_idx_reg;
                mem_wdata = {lsp_pkg::SLOT_RUNNING, mem_rdata[7:0]};
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsp_pkg::LSP_IDLE;
            modulus_reg   <= lsp_pkg::MODULUS_RESET;
            seed_reg      <= lsp_pkg::SEED_RESET;
            total_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && paddr[2] == lsp_pkg::REG_MODULUS)
                modulus_reg <= pwdata[15:0];
            if (mem_we)
                valid_reg[mem_waddr] <= 1'b1;
            if (state_reg == lsp_pkg::LSP_SET_WR)
                total_reg <= total_next;
            if (state_reg == lsp_pkg::LSP_MOD_SEED && div_last)
                seed_reg <= div_rem_step[15:0];
            if (state_reg == lsp_pkg::LSP_SCAN)
                rd_live_reg <= 1'b1;
            else
                rd_live_reg <= 1'b0;
            if (state_reg == lsp_pkg::LSP_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[mem_raddr];
        if (accept)
        begin
            op_reg         <= operation;
            slot_reg       <= IW'(slot);
            new_state_reg  <= new_state;
            nice_reg       <= nice_value;
            res_found_reg  <= 1'b0;
            res_winner_reg <= '0;
            res_draw_reg   <= '0;
        end
        case (state_reg)
            lsp_pkg::LSP_MUL:
            begin
                div_dvd_reg <= 32'(seed_reg) * 32'(seed_reg);
                div_rem_reg <= '0;
                div_dsr_reg <= {(modulus_reg == 16'd0), modulus_reg};
                div_cnt_reg <= '0;
            end
            lsp_pkg::LSP_MOD_SEED:
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_last)
                begin
                    div_dvd_reg <= {16'd0, div_rem_step[15:0]};
                    div_rem_reg <= '0;
                    div_dsr_reg <= 17'(total_reg);
                end
                else
                begin
                    div_dvd_reg <= {div_dvd_reg[30:0], 1'b0};
                    div_rem_reg <= div_rem_step;
                end
            end
            lsp_pkg::LSP_MOD_DRAW:
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                div_dvd_reg <= {div_dvd_reg[30:0], 1'b0};
                div_rem_reg <= div_rem_step;
                if (div_last)
                begin
                    res_draw_reg  <= TW'(div_rem_step);
                    issue_idx_reg <= '0;
                    sum_reg       <= '0;
                end
            end
            lsp_pkg::LSP_SCAN:
            begin
                rd_idx_reg <= issue_idx_reg;
                if (issue_idx_reg != IW'(SLOTS - 1))
                    issue_idx_reg <= issue_idx_reg + IW'(1);
                sum_reg <= sum_step;
                if (scan_win)
                begin
                    res_found_reg  <= 1'b1;
                    res_winner_reg <= rd_idx_reg;
                end
            end
            default:
            begin
                div_cnt_reg <= div_cnt_reg;
            end
        endcase
        if (state_reg == lsp_pkg::LSP_DONE && out_free)
        begin
            found_reg        <= res_found_reg;
            winner_slot_reg  <= 6'(res_winner_reg);
            draw_value_reg   <= 9'(res_draw_reg);
            ticket_total_reg <= 9'(total_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign winner_slot  = winner_slot_reg;
    assign draw_value   = draw_value_reg;
    assign ticket_total = ticket_total_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lsp_pkg::REG_MODULUS) ? {16'd0, modulus_reg} : 32'd0;

    // a draw item with a nonzero total goes through the divider, a set item never does
    a_op_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsp_pkg::LSP_MUL) |-> (op_reg == lsp_pkg::OP_DRAW))
        else $error("divider entered by a set transaction");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsp_pkg::LSP_SET_WR) |=> (32'(total_reg) <= TOTAL_MAX))
        else $error("ticket total beyond table capacity");

    a_win_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsp_pkg::LSP_SCAN && mem_we) |=> (state_reg == lsp_pkg::LSP_DONE))
        else $error("scan continued after marking a winner");

    a_draw_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsp_pkg::LSP_DONE && res_found_reg) |-> (res_draw_reg < total_reg))
        else $error("winner found with draw not below total");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsp_pkg::LSP_DONE && out_valid_reg && out_stall)
        |=> (state_reg == lsp_pkg::LSP_DONE))
        else $error("result left pending while output stalled");

endmodule

@@ rtl/lsp_ram.sv @@
module lsp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
